FILE: rtl/core/double_ended_queue_with_insert_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_INSERT_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_INSERT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DEQI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DEQI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/deqi_pkg.sv
// ----------------------------------------------------------------------------
// deqi_pkg
// Types and fixed constants of the double-ended queue with insert.
// ----------------------------------------------------------------------------
package deqi_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int OCC_W  = 7;
   localparam int STAT_W = 2;
   // cells per group in the pop gather tree
   localparam int GRP    = 32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_INSERT     = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // what every cell does on the current cycle
   typedef enum logic [1:0] {
      ACT_HOLD      = 2'd0,
      ACT_OPEN_GAP  = 2'd1,
      ACT_CLOSE_GAP = 2'd2
   } cell_act_type;

   typedef struct packed {
      cell_act_type act;
      logic         tap_en;
   } cell_ctl_type;

endpackage

FILE: rtl/core/deqi_channels.sv
// ----------------------------------------------------------------------------
// deqi channels
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface deqi_req_if
   import deqi_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface deqi_rsp_if
   import deqi_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] popped;
   logic [STAT_W-1:0]        status;
   logic [OCC_W-1:0]         occupancy;
   logic                     is_empty;

   modport source (output valid, output popped, output status, output occupancy,
                   output is_empty, input ready);
   modport sink   (input valid, input popped, input status, input occupancy,
                   input is_empty, output ready);
endinterface

FILE: rtl/core/deqi_cell.sv
// ----------------------------------------------------------------------------
// deqi_cell
// One storage cell of the shifting row; takes its left or right neighbor,
// the new word, or holds, and drives its word onto the gather tap.
// ----------------------------------------------------------------------------
module deqi_cell
   import deqi_pkg::*;
   #(
      parameter int DEPTH = 64,
      parameter int IDX   = 0
   )
   (
      input  logic                        clock,
      input  cell_ctl_type                ctl,
      input  logic [$clog2(DEPTH+1)-1:0]  at,
      input  logic [$clog2(DEPTH+1)-1:0]  sel,
      input  logic [DATA_W-1:0]           value,
      input  logic [DATA_W-1:0]           left_data,
      input  logic [DATA_W-1:0]           right_data,
      output logic [DATA_W-1:0]           data,
      output logic [DATA_W-1:0]           tap
   );

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] MY_IDX = CW'(IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // next word for this cell
   always_comb begin
      data_in = data_ff;
      unique case (ctl.act)
         ACT_OPEN_GAP: begin
            if (MY_IDX == at) begin
               data_in = value;
            end else if (MY_IDX > at) begin
               data_in = left_data;
            end
         end
         ACT_CLOSE_GAP: data_in = right_data;
         ACT_HOLD:      data_in = data_ff;
         default:       data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // only the selected cell shows its word to the gather tree
   assign tap  = (ctl.tap_en && (MY_IDX == sel)) ? data_ff : '0;
   assign data = data_ff;

endmodule

FILE: rtl/core/deqi_gather.sv
// ----------------------------------------------------------------------------
// deqi_gather
// Two-level OR tree that collects the one selected cell word; the group
// level is registered, the final level is left for the output register.
// ----------------------------------------------------------------------------
module deqi_gather
   import deqi_pkg::*;
   #(
      parameter int DEPTH = 64
   )
   (
      input  logic              clock,
      input  logic              capture,
      input  logic [DATA_W-1:0] taps [DEPTH],
      output logic [DATA_W-1:0] folded
   );

   localparam int NGRP = (DEPTH + GRP - 1) / GRP;
   localparam int NPAD = NGRP * GRP;

   logic [DATA_W-1:0] padded   [NPAD];
   logic [DATA_W-1:0] group_in [NGRP];
   logic [DATA_W-1:0] group_ff [NGRP];

   // pad the taps up to whole groups
   for (genvar i = 0; i < NPAD; i++) begin : g_pad
      if (i < DEPTH) begin : g_real
         assign padded[i] = taps[i];
      end else begin : g_zero
         assign padded[i] = '0;
      end
   end

   // first level: one OR per group, registered on capture
   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      always_comb begin
         group_in[g] = '0;
         for (int k = 0; k < GRP; k++) begin
            group_in[g] = group_in[g] | padded[g*GRP + k];
         end
      end

      always_ff @(posedge clock) begin
         if (capture) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   // second level over the group results
   always_comb begin
      folded = '0;
      for (int g = 0; g < NGRP; g++) begin
         folded = folded | group_ff[g];
      end
   end

endmodule

FILE: rtl/core/double_ended_queue_with_insert_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_insert_unit
// Bounded double-ended queue of 32-bit words with positional insert.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request per beat: op (push front, push back, pop
//   front, pop back, insert before position), value and position. rsp_bus
//   returns exactly one beat per request: popped word, status, occupancy
//   and the empty flag, all describing the queue after the request.
//   Storage is a row of DEPTH shifting cells; cell 0 is the front. A push
//   or insert opens a gap by shifting the upper cells right as the request
//   is accepted, a pop front closes it by shifting left, a pop back only
//   drops the count. Sequence: the request is accepted in S_IDLE, where
//   the selected cell word enters the registered group level of the
//   two-level OR tree; in S_GATHER the final level feeds the single
//   response register, and the response is valid in S_RESP. One request
//   is in flight at a time; a new one is taken once the response is taken.
//   A stalled receiver holds the response; req_bus.ready stays low until it
//   is taken. Reset empties the queue at once; no clearing pass is run and
//   cell contents are don't-care until written.
// ----------------------------------------------------------------------------
module double_ended_queue_with_insert_unit
   import deqi_pkg::*;
   #(
      parameter int DEPTH = 64
   )
   (
      input  logic         clock,
      input  logic         reset,
      deqi_req_if.sink     req_bus,
      deqi_rsp_if.source   rsp_bus
   );

   localparam int CW = $clog2(DEPTH+1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_GATHER = 3'b010,
      S_RESP   = 3'b100
   } fsm_type;

   fsm_type           state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   status_type        status_ff, status_in;
   logic [OCC_W-1:0]  occ_ff;
   logic              empty_ff;
   logic [DATA_W-1:0] popped_ff;

   logic              accept;
   logic              is_full, is_zero;
   logic [PW-1:0]     pos_ext, cnt_ext;
   cell_ctl_type      ctl;
   logic [CW-1:0]     at, sel;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] taps      [DEPTH];
   logic [DATA_W-1:0] folded;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // request decode: cell command, new count and status
   assign is_full = (count_ff == CW'(DEPTH));
   assign is_zero = (count_ff == '0);
   assign pos_ext = PW'(req_bus.position);
   assign cnt_ext = PW'(count_ff);

   always_comb begin
      ctl       = '{act: ACT_HOLD, tap_en: 1'b0};
      at        = '0;
      sel       = '0;
      status_in = ST_OK;
      count_in  = count_ff;
      if (accept) begin
         unique case (req_bus.op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.act  = ACT_OPEN_GAP;
                  count_in = count_ff + CW'(1);
                  if (req_bus.op == OP_PUSH_FRONT) begin
                     at = '0;
                  end else if (req_bus.op == OP_PUSH_BACK) begin
                     at = count_ff;
                  end else begin
                     at = (pos_ext >= cnt_ext) ? count_ff : CW'(req_bus.position);
                  end
               end
            end
            OP_POP_FRONT: begin
               if (is_zero) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctl.act    = ACT_CLOSE_GAP;
                  ctl.tap_en = 1'b1;
                  sel        = '0;
                  count_in   = count_ff - CW'(1);
               end
            end
            OP_POP_BACK: begin
               if (is_zero) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctl.tap_en = 1'b1;
                  sel        = count_ff - CW'(1);
                  count_in   = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // row of shifting cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data, right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
      end

      deqi_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .at         (at),
         .sel        (sel),
         .value      (req_bus.value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .tap        (taps[i])
      );
   end

   // gather tree for the popped word
   deqi_gather #(.DEPTH(DEPTH)) u_gather (
      .clock   (clock),
      .capture (accept),
      .taps    (taps),
      .folded  (folded)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_GATHER;
         S_GATHER: state_in = S_RESP;
         S_RESP:   if (rsp_bus.ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         occ_ff    <= OCC_W'(count_in);
         empty_ff  <= (count_in == '0);
      end
      if (state_ff == S_GATHER) begin
         popped_ff <= folded;
      end
   end

   assign rsp_bus.valid     = (state_ff == S_RESP);
   assign rsp_bus.popped    = popped_ff;
   assign rsp_bus.status    = status_ff;
   assign rsp_bus.occupancy = occ_ff;
   assign rsp_bus.is_empty  = empty_ff;

endmodule

FILE: rtl/core/deqi_checker.sv
// ----------------------------------------------------------------------------
// deqi_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_insert_unit_macros.svh"

module deqi_checker
   import deqi_pkg::*;
   (
      input logic                     clock,
      input logic                     reset,
      input logic                     req_valid,
      input logic                     req_ready,
      input logic                     rsp_valid,
      input logic                     rsp_ready,
      input logic signed [DATA_W-1:0] rsp_popped,
      input logic [STAT_W-1:0]        rsp_status,
      input logic [OCC_W-1:0]         rsp_occupancy,
      input logic                     rsp_is_empty
   );

   // a pending response holds until taken
   `DEQI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // no new request while a response is pending
   `DEQI_ASSERT_IMPLY(a_one_in_flight, clock, reset, rsp_valid, !req_ready, "request taken with response pending")

   // a response never shows in the beat right after acceptance
   `DEQI_ASSERT_NEXT(a_gather_gap, clock, reset, req_valid && req_ready, !rsp_valid, "response skipped gather cycle")

   // empty flag agrees with occupancy
   `DEQI_ASSERT_IMPLY(a_empty_occ, clock, reset, rsp_valid && rsp_is_empty, rsp_occupancy == '0, "empty flag with nonzero occupancy")

   // pop on empty leaves nothing popped and an empty queue
   `DEQI_ASSERT_IMPLY(a_empty_pop, clock, reset, rsp_valid && (rsp_status == ST_EMPTY), rsp_is_empty && (rsp_popped == '0), "bad empty-pop response")

endmodule

bind double_ended_queue_with_insert_unit deqi_checker u_deqi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_popped    (rsp_bus.popped),
   .rsp_status    (rsp_bus.status),
   .rsp_occupancy (rsp_bus.occupancy),
   .rsp_is_empty  (rsp_bus.is_empty)
);
